[src/aetc_pkg.sv]
// Shared types, constants and the colour palette for the text cursor unit.
// No dependencies; every other file refers to it by scoped names.
package aetc_pkg;

  // Screen geometry and parser sizes
  localparam int unsigned ScreenCols = 80;
  localparam int unsigned ScreenRows = 25;
  localparam int unsigned StackDepth = 8;
  // Tab stop spacing; must be a power of two (the next stop is found by masking)
  localparam int unsigned TabStop    = 4;

  localparam int unsigned StackIdxW  = $clog2(StackDepth);
  localparam int unsigned StackCntW  = $clog2(StackDepth + 1);
  localparam int unsigned CharW      = 8;
  localparam int unsigned PosW       = 8;
  localparam int unsigned AccW       = 16;
  localparam int unsigned RgbW       = 24;

  // Cursor arithmetic runs one bit wider than a position to catch overflow
  localparam logic [PosW:0] Cols9    = (PosW + 1)'(ScreenCols);
  localparam logic [PosW:0] Rows9    = (PosW + 1)'(ScreenRows);
  localparam logic [PosW:0] TabStep9 = (PosW + 1)'(TabStop);
  localparam logic [PosW:0] TabMask9 = (PosW + 1)'(TabStop - 1);

  // Byte codes
  localparam logic [CharW-1:0] CharEsc     = 8'h1B;
  localparam logic [CharW-1:0] CharBracket = 8'h5B;
  localparam logic [CharW-1:0] CharSemi    = 8'h3B;
  localparam logic [CharW-1:0] CharSave    = 8'h73;
  localparam logic [CharW-1:0] CharRestore = 8'h75;
  localparam logic [CharW-1:0] CharSgr     = 8'h6D;
  localparam logic [CharW-1:0] CharCupH    = 8'h48;
  localparam logic [CharW-1:0] CharCupF    = 8'h66;
  localparam logic [CharW-1:0] CharErase   = 8'h4A;
  localparam logic [CharW-1:0] CharBs      = 8'h08;
  localparam logic [CharW-1:0] CharTab     = 8'h09;
  localparam logic [CharW-1:0] CharLf      = 8'h0A;
  localparam logic [CharW-1:0] CharCr      = 8'h0D;
  localparam logic [CharW-1:0] CharZero    = 8'h30;
  localparam logic [CharW-1:0] CharNine    = 8'h39;

  // Attribute and erase values
  localparam logic [AccW-1:0] AttrReset   = 16'd0;
  localparam logic [AccW-1:0] AttrFgLo    = 16'd30;
  localparam logic [AccW-1:0] AttrFgHi    = 16'd37;
  localparam logic [AccW-1:0] AttrBgLo    = 16'd40;
  localparam logic [AccW-1:0] AttrBgHi    = 16'd47;
  localparam logic [AccW-1:0] AttrFgBrLo  = 16'd90;
  localparam logic [AccW-1:0] AttrFgBrHi  = 16'd97;
  localparam logic [AccW-1:0] AttrBgBrLo  = 16'd100;
  localparam logic [AccW-1:0] AttrBgBrHi  = 16'd107;
  localparam logic [AccW-1:0] EraseScreen = 16'd2;

  localparam logic [RgbW-1:0] ResetFore = 24'hFFFFFF;
  localparam logic [RgbW-1:0] ResetBack = 24'h000000;

  // Configuration register indexes
  localparam logic CfgDefaultFore = 1'b0;
  localparam logic CfgDefaultBack = 1'b1;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindDraw  = 2'd1,
    KindClear = 2'd2,
    KindError = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhNormal  = 2'd0,
    PhEsc     = 2'd1,
    PhBracket = 2'd2,
    PhValue   = 2'd3
  } phase_e;

  // How the controller has to sequence the byte held in the datapath
  typedef enum logic [1:0] {
    ClsSimple = 2'd0,
    ClsColour = 2'd1,
    ClsPrint  = 2'd2
  } dec_cls_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic apply;
    logic draw;
    logic advance;
    logic emit;
  } cmd_t;

  typedef struct packed {
    dec_cls_e cls;
    logic     apply_last;
    logic     out_free;
  } status_t;

  function automatic logic [RgbW-1:0] palette(input logic [3:0] idx);
    logic [RgbW-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hAA0000;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'hAA5500;
      4'd4:    rgb = 24'h0000AA;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'h00AAAA;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'hFF5555;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'hFFFF55;
      4'd12:   rgb = 24'h5555FF;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'h55FFFF;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

[src/aetc_ctrl.sv]
// Sequencer of the text cursor unit: one-hot state machine issuing datapath commands.
// Depends on aetc_pkg for the command and status structs.
module aetc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aetc_pkg::status_t sts_i,
  output aetc_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecode = 6'b000010,
    StApply  = 6'b000100,
    StDraw   = 6'b001000,
    StStep   = 6'b010000,
    StEmit   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        case (sts_i.cls)
          aetc_pkg::ClsColour: begin
            cmd_o.exec = 1'b1;
            state_d    = StApply;
          end
          aetc_pkg::ClsPrint: begin
            state_d = StDraw;
          end
          default: begin
            cmd_o.exec = 1'b1;
            state_d    = StEmit;
          end
        endcase
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        if (sts_i.apply_last) begin
          state_d = StEmit;
        end
      end
      StDraw: begin
        cmd_o.draw = 1'b1;
        state_d    = StStep;
      end
      StStep: begin
        cmd_o.advance = 1'b1;
        state_d       = StEmit;
      end
      StEmit: begin
        // hold until the output slot is free
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

[src/aetc_dp.sv]
// Datapath of the text cursor unit: parser state, value stack, cursor, colours, result.
// Depends on aetc_pkg; driven by aetc_ctrl through cmd_t, reports through status_t.
module aetc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aetc_pkg::cmd_t              cmd_i,
  output aetc_pkg::status_t           sts_o,
  input  logic [aetc_pkg::CharW-1:0]  char_code_i,
  input  logic                        out_stall_i,
  input  logic                        cfg_wr_i,
  input  logic                        cfg_index_i,
  input  logic [aetc_pkg::RgbW-1:0]   cfg_data_i,
  output logic                        out_valid_o,
  output aetc_pkg::kind_e             out_kind_o,
  output logic [aetc_pkg::CharW-1:0]  out_code_o,
  output logic [aetc_pkg::PosW-1:0]   out_col_o,
  output logic [aetc_pkg::PosW-1:0]   out_row_o,
  output logic [aetc_pkg::RgbW-1:0]   out_fore_o,
  output logic [aetc_pkg::RgbW-1:0]   out_back_o
);

  localparam int unsigned CharW     = aetc_pkg::CharW;
  localparam int unsigned PosW      = aetc_pkg::PosW;
  localparam int unsigned AccW      = aetc_pkg::AccW;
  localparam int unsigned RgbW      = aetc_pkg::RgbW;
  localparam int unsigned StackIdxW = aetc_pkg::StackIdxW;
  localparam int unsigned StackCntW = aetc_pkg::StackCntW;
  localparam logic [StackCntW-1:0] DepthCnt = StackCntW'(aetc_pkg::StackDepth);
  localparam logic [StackIdxW-1:0] LastIdx  = StackIdxW'(aetc_pkg::StackDepth - 1);

  // saturate a stacked value onto the screen
  function automatic logic [PosW-1:0] sat_pos(input logic [AccW-1:0] v,
                                               input logic [PosW:0]   limit);
    logic [PosW-1:0] r;
    if (v >= AccW'(limit)) begin
      r = PosW'(limit - 1'b1);
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

  // Registers
  logic [CharW-1:0]     char_q;
  aetc_pkg::phase_e     phase_q, phase_d;
  logic [AccW-1:0]      accum_q, accum_d;
  logic [StackCntW-1:0] count_q, count_d;
  logic [StackIdxW-1:0] idx_q, idx_d;
  logic [AccW-1:0]      stack_q [aetc_pkg::StackDepth];
  logic [PosW-1:0]      col_q, col_d, row_q, row_d;
  logic [PosW-1:0]      scol_q, scol_d, srow_q, srow_d;
  logic [RgbW-1:0]      fore_q, fore_d, back_q, back_d;
  logic [RgbW-1:0]      dfore_q, dback_q;

  aetc_pkg::kind_e      pk_kind_q, pk_kind_d;
  logic [CharW-1:0]     pk_code_q, pk_code_d;
  logic [PosW-1:0]      pk_col_q, pk_col_d, pk_row_q, pk_row_d;
  logic [RgbW-1:0]      pk_fore_q, pk_fore_d, pk_back_q, pk_back_d;

  logic                 out_valid_q;
  aetc_pkg::kind_e      out_kind_q;
  logic [CharW-1:0]     out_code_q;
  logic [PosW-1:0]      out_col_q, out_row_q;
  logic [RgbW-1:0]      out_fore_q, out_back_q;

  logic                 push_en;

  // Byte classification
  logic                 is_digit;
  logic [AccW-1:0]      digit_val;
  logic                 is_simple, is_colour;

  assign is_digit  = (char_q >= aetc_pkg::CharZero) && (char_q <= aetc_pkg::CharNine);
  assign digit_val = AccW'(char_q - aetc_pkg::CharZero);

  always_comb begin
    is_simple = 1'b0;
    is_colour = 1'b0;
    unique case (phase_q)
      aetc_pkg::PhNormal:  is_simple = (char_q == aetc_pkg::CharEsc);
      aetc_pkg::PhEsc:     is_simple = (char_q == aetc_pkg::CharBracket);
      aetc_pkg::PhBracket: is_simple = is_digit || (char_q == aetc_pkg::CharSave) ||
                                       (char_q == aetc_pkg::CharRestore);
      aetc_pkg::PhValue: begin
        is_simple = is_digit || (char_q == aetc_pkg::CharSemi) ||
                    (char_q == aetc_pkg::CharCupH) || (char_q == aetc_pkg::CharCupF) ||
                    (char_q == aetc_pkg::CharErase);
        is_colour = (char_q == aetc_pkg::CharSgr);
      end
      default: ;
    endcase
  end

  assign sts_o.cls        = is_colour ? aetc_pkg::ClsColour :
                            is_simple ? aetc_pkg::ClsSimple : aetc_pkg::ClsPrint;
  assign sts_o.apply_last = (idx_q == '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Cursor arithmetic for a drawn glyph
  logic [PosW:0] dc, dr, ac, ar;
  logic [AccW-1:0] attr;

  always_comb begin
    dc = {1'b0, col_q};
    dr = {1'b0, row_q};
    case (char_q)
      aetc_pkg::CharBs: begin
        if (col_q != '0) begin
          dc = dc - 1'b1;
        end
      end
      aetc_pkg::CharLf: begin
        dc = '0;
        dr = dr + 1'b1;
      end
      aetc_pkg::CharTab: dc = (dc & ~aetc_pkg::TabMask9) + aetc_pkg::TabStep9;
      aetc_pkg::CharCr:  dc = '0;
      default: ;
    endcase
    if (dc >= aetc_pkg::Cols9) begin
      dc = '0;
      dr = dr + 1'b1;
    end
    if (dr >= aetc_pkg::Rows9) begin
      dr = aetc_pkg::Rows9 - 1'b1;
    end
  end

  // Cursor step after a draw
  always_comb begin
    ac = {1'b0, col_q} + 1'b1;
    ar = {1'b0, row_q};
    if (ac >= aetc_pkg::Cols9) begin
      ac = '0;
      ar = ar + 1'b1;
    end
    if (ar >= aetc_pkg::Rows9) begin
      ac = '0;
      ar = aetc_pkg::Rows9 - 1'b1;
    end
  end

  assign attr = stack_q[idx_q];

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    count_d   = count_q;
    idx_d     = idx_q;
    col_d     = col_q;
    row_d     = row_q;
    scol_d    = scol_q;
    srow_d    = srow_q;
    fore_d    = fore_q;
    back_d    = back_q;
    pk_kind_d = pk_kind_q;
    pk_code_d = pk_code_q;
    pk_col_d  = pk_col_q;
    pk_row_d  = pk_row_q;
    pk_fore_d = pk_fore_q;
    pk_back_d = pk_back_q;
    push_en   = 1'b0;

    if (cmd_i.exec) begin
      pk_kind_d = aetc_pkg::KindNone;
      pk_code_d = '0;
      pk_col_d  = '0;
      pk_row_d  = '0;
      pk_fore_d = '0;
      pk_back_d = '0;
      unique case (phase_q)
        aetc_pkg::PhNormal: phase_d = aetc_pkg::PhEsc;
        aetc_pkg::PhEsc:    phase_d = aetc_pkg::PhBracket;
        aetc_pkg::PhBracket: begin
          if (is_digit) begin
            accum_d = digit_val;
            phase_d = aetc_pkg::PhValue;
          end else begin
            if (char_q == aetc_pkg::CharSave) begin
              scol_d = col_q;
              srow_d = row_q;
            end else begin
              col_d = scol_q;
              row_d = srow_q;
            end
            phase_d = aetc_pkg::PhNormal;
            accum_d = '0;
            count_d = '0;
          end
        end
        aetc_pkg::PhValue: begin
          if (is_digit) begin
            accum_d = (accum_q << 3) + (accum_q << 1) + digit_val;
          end else if (char_q == aetc_pkg::CharSemi) begin
            push_en = 1'b1;
            if (count_q < DepthCnt) begin
              count_d = count_q + 1'b1;
            end
            accum_d = '0;
            phase_d = aetc_pkg::PhBracket;
          end else begin
            // every terminator returns to normal text
            phase_d = aetc_pkg::PhNormal;
            accum_d = '0;
            count_d = '0;
            if (char_q == aetc_pkg::CharSgr) begin
              // push the last value and walk the stack from its top
              push_en = 1'b1;
              idx_d   = (count_q < DepthCnt) ? count_q[StackIdxW-1:0] : LastIdx;
            end else if (char_q == aetc_pkg::CharErase) begin
              pk_kind_d = (accum_q == aetc_pkg::EraseScreen) ? aetc_pkg::KindClear
                                                            : aetc_pkg::KindError;
            end else begin
              // cursor position: row only, or row then column
              if (count_q == '0) begin
                row_d = sat_pos(accum_q, aetc_pkg::Rows9);
                col_d = '0;
              end else if (count_q == StackCntW'(1)) begin
                row_d = sat_pos(stack_q[0], aetc_pkg::Rows9);
                col_d = sat_pos(accum_q, aetc_pkg::Cols9);
              end else begin
                pk_kind_d = aetc_pkg::KindError;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.apply) begin
      if (attr == aetc_pkg::AttrReset) begin
        fore_d = dfore_q;
        back_d = dback_q;
      end else if (attr >= aetc_pkg::AttrFgLo && attr <= aetc_pkg::AttrFgHi) begin
        fore_d = aetc_pkg::palette({1'b0, 3'(attr - aetc_pkg::AttrFgLo)});
      end else if (attr >= aetc_pkg::AttrBgLo && attr <= aetc_pkg::AttrBgHi) begin
        back_d = aetc_pkg::palette({1'b0, 3'(attr - aetc_pkg::AttrBgLo)});
      end else if (attr >= aetc_pkg::AttrFgBrLo && attr <= aetc_pkg::AttrFgBrHi) begin
        fore_d = aetc_pkg::palette({1'b1, 3'(attr - aetc_pkg::AttrFgBrLo)});
      end else if (attr >= aetc_pkg::AttrBgBrLo && attr <= aetc_pkg::AttrBgBrHi) begin
        back_d = aetc_pkg::palette({1'b1, 3'(attr - aetc_pkg::AttrBgBrLo)});
      end
      idx_d = idx_q - 1'b1;
    end

    if (cmd_i.draw) begin
      phase_d   = aetc_pkg::PhNormal;
      accum_d   = '0;
      count_d   = '0;
      col_d     = dc[PosW-1:0];
      row_d     = dr[PosW-1:0];
      pk_kind_d = aetc_pkg::KindDraw;
      pk_code_d = char_q;
      pk_col_d  = dc[PosW-1:0];
      pk_row_d  = dr[PosW-1:0];
      pk_fore_d = fore_q;
      pk_back_d = back_q;
    end

    if (cmd_i.advance) begin
      col_d = ac[PosW-1:0];
      row_d = ar[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aetc_pkg::PhNormal;
      accum_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      scol_q  <= '0;
      srow_q  <= '0;
      fore_q  <= aetc_pkg::ResetFore;
      back_q  <= aetc_pkg::ResetBack;
      dfore_q <= aetc_pkg::ResetFore;
      dback_q <= aetc_pkg::ResetBack;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
      scol_q  <= scol_d;
      srow_q  <= srow_d;
      fore_q  <= fore_d;
      back_q  <= back_d;
      if (cfg_wr_i) begin
        if (cfg_index_i == aetc_pkg::CfgDefaultFore) begin
          dfore_q <= cfg_data_i;
        end else begin
          dback_q <= cfg_data_i;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= char_code_i;
    end
    if (push_en && (count_q < DepthCnt)) begin
      stack_q[count_q[StackIdxW-1:0]] <= accum_q;
    end
    pk_kind_q <= pk_kind_d;
    pk_code_q <= pk_code_d;
    pk_col_q  <= pk_col_d;
    pk_row_q  <= pk_row_d;
    pk_fore_q <= pk_fore_d;
    pk_back_q <= pk_back_d;
    if (cmd_i.emit) begin
      out_kind_q <= pk_kind_q;
      out_code_q <= pk_code_q;
      out_col_q  <= pk_col_q;
      out_row_q  <= pk_row_q;
      out_fore_q <= pk_fore_q;
      out_back_q <= pk_back_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_code_o  = out_code_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_fore_o  = out_fore_q;
  assign out_back_o  = out_back_q;

endmodule

[src/ansi_escape_text_cursor_unit.sv]
// Top level of the text console byte parser with ANSI cursor and colour sequences.
// Depends on aetc_pkg, aetc_ctrl and aetc_dp.
//
//   Channel   Direction   Handshake                  Carries
//   ------    ---------   -------------------------  ---------------------------------
//   in        sink        in_valid_i / in_stall_o    char_code_i
//   out       source      out_valid_o / out_stall_i  result_kind_o, glyph_*_o
//   cfg       sink        cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Steps: a byte is taken in an idle cycle, then decoded in the next. Sequence bytes
// then go to emit, printed glyphs pass through draw, cursor step and emit, and a
// colour command applies each stacked value in turn (up to 8) before emit, walked by the
// single stack read port in the datapath.
// Reset clears parser, cursor and colour state at once; no clearing pass.
// A stalled output holds its transaction; the next byte is still accepted and waits
// in the emit step until the output register drains.
module ansi_escape_text_cursor_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [aetc_pkg::CharW-1:0]  char_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  result_kind_o,
  output logic [aetc_pkg::CharW-1:0]  glyph_code_o,
  output logic [aetc_pkg::PosW-1:0]   glyph_col_o,
  output logic [aetc_pkg::PosW-1:0]   glyph_row_o,
  output logic [aetc_pkg::RgbW-1:0]   glyph_fore_o,
  output logic [aetc_pkg::RgbW-1:0]   glyph_back_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [aetc_pkg::RgbW-1:0]   cfg_data_i
);

  aetc_pkg::cmd_t    cmd;
  aetc_pkg::status_t sts;
  aetc_pkg::kind_e   out_kind;

  // Configuration writes are always ready
  assign cfg_ready_o = 1'b1;

  aetc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aetc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_code_i (char_code_i),
    .out_stall_i (out_stall_i),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_kind_o  (out_kind),
    .out_code_o  (glyph_code_o),
    .out_col_o   (glyph_col_o),
    .out_row_o   (glyph_row_o),
    .out_fore_o  (glyph_fore_o),
    .out_back_o  (glyph_back_o)
  );

  assign result_kind_o = out_kind;

endmodule

[src/aetc_chk.sv]
// Port-level checker for the text cursor unit, bound to the top level.
// Depends on aetc_pkg for screen limits and result kinds.
module aetc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  result_kind_o,
  input logic [aetc_pkg::CharW-1:0]  glyph_code_o,
  input logic [aetc_pkg::PosW-1:0]   glyph_col_o,
  input logic [aetc_pkg::PosW-1:0]   glyph_row_o,
  input logic [aetc_pkg::RgbW-1:0]   glyph_fore_o,
  input logic [aetc_pkg::RgbW-1:0]   glyph_back_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(glyph_code_o) && $stable(glyph_col_o) && $stable(glyph_row_o))
    else $error("stalled result changed");

  // One byte at a time: busy right after a byte is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("byte taken while previous one in flight");

  // Non-draw results carry zero glyph fields
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != aetc_pkg::KindDraw) |->
      glyph_code_o == '0 && glyph_col_o == '0 && glyph_row_o == '0 &&
      glyph_fore_o == '0 && glyph_back_o == '0)
    else $error("glyph fields set on a non-draw result");

  // Glyphs land on the screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == aetc_pkg::KindDraw) |->
      (glyph_col_o < aetc_pkg::PosW'(aetc_pkg::ScreenCols)) &&
      (glyph_row_o < aetc_pkg::PosW'(aetc_pkg::ScreenRows)))
    else $error("glyph drawn off screen");

endmodule

bind ansi_escape_text_cursor_unit aetc_chk u_aetc_chk (.*);
